@@ rtl/c8x_pkg.sv @@
// Shared types, opcode constants and the hex font table for the CHIP-8 executor.
`timescale 1ns / 1ps
`default_nettype none
package c8x_pkg;

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] DISP_NONE  = 2'd0;
    localparam logic [1:0] DISP_CLEAR = 2'd1;
    localparam logic [1:0] DISP_DRAW  = 2'd2;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [3:0] GRP_JP    = 4'h1;
    localparam logic [3:0] GRP_CALL  = 4'h2;
    localparam logic [3:0] GRP_SE    = 4'h3;
    localparam logic [3:0] GRP_SNE   = 4'h4;
    localparam logic [3:0] GRP_SER   = 4'h5;
    localparam logic [3:0] GRP_LD    = 4'h6;
    localparam logic [3:0] GRP_ADD   = 4'h7;
    localparam logic [3:0] GRP_ALU   = 4'h8;
    localparam logic [3:0] GRP_SNER  = 4'h9;
    localparam logic [3:0] GRP_LDI   = 4'hA;
    localparam logic [3:0] GRP_JPV0  = 4'hB;
    localparam logic [3:0] GRP_RND   = 4'hC;
    localparam logic [3:0] GRP_DRW   = 4'hD;
    localparam logic [3:0] GRP_KEY   = 4'hE;
    localparam logic [3:0] GRP_MISC  = 4'hF;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KK_SKP   = 8'h9E;
    localparam logic [7:0] KK_SKNP  = 8'hA1;
    localparam logic [7:0] KK_GETDT = 8'h07;
    localparam logic [7:0] KK_WAITK = 8'h0A;
    localparam logic [7:0] KK_SETDT = 8'h15;
    localparam logic [7:0] KK_SETST = 8'h18;
    localparam logic [7:0] KK_ADDI  = 8'h1E;
    localparam logic [7:0] KK_FONT  = 8'h29;
    localparam logic [7:0] KK_BCD   = 8'h33;
    localparam logic [7:0] KK_STORE = 8'h55;
    localparam logic [7:0] KK_LOAD  = 8'h65;

    localparam int FONT_BYTES = 80;
    localparam logic [3:0] VF_IDX = 4'hF;

    typedef struct packed {
        logic       vx_we;
        logic [7:0] vx_val;
        logic       vf_we;
        logic [7:0] vf_val;
        logic       skip;
        logic       hold;
    } alu_res_t;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] b;
        case (a)
            7'd0:  b = 8'hF0; 7'd1:  b = 8'h90; 7'd2:  b = 8'h90; 7'd3:  b = 8'h90;
            7'd4:  b = 8'hF0; 7'd5:  b = 8'h20; 7'd6:  b = 8'h60; 7'd7:  b = 8'h20;
            7'd8:  b = 8'h20; 7'd9:  b = 8'h70; 7'd10: b = 8'hF0; 7'd11: b = 8'h10;
            7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
            7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
            7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
            7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
            7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
            7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
            7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
            7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
            7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
            7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
            7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
            7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
            7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
            7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
            7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
            7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
            7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

@@ rtl/c8x_if.sv @@
// Request and response channel interfaces of the CHIP-8 executor.
`timescale 1ns / 1ps
`default_nettype none
interface c8x_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] opcode;
    logic [15:0] keys_down;
    logic [7:0]  random_byte;
    logic [11:0] mem_addr;
    logic [7:0]  mem_data;
    modport source (output valid, action, opcode, keys_down, random_byte, mem_addr,
                    mem_data, input ready);
    modport sink (input valid, action, opcode, keys_down, random_byte, mem_addr,
                  mem_data, output ready);
endinterface

interface c8x_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] next_pc;
    logic [1:0]  display_op;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [11:0] draw_addr;
    logic [3:0]  draw_rows;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
    logic [7:0]  read_data;
    modport source (output valid, next_pc, display_op, draw_x, draw_y, draw_addr,
                    draw_rows, delay_value, sound_value, read_data, input ready);
    modport sink (input valid, next_pc, display_op, draw_x, draw_y, draw_addr,
                  draw_rows, delay_value, sound_value, read_data, output ready);
endinterface
`default_nettype wire

@@ rtl/chip8_instruction_execute.sv @@
// CHIP-8 executor top level: sequencer, register file, stack and byte memory.
//
// Requests arrive on req: execute an opcode, write a memory byte or read one.
// Each accepted request gives exactly one response on rsp with the new PC,
// timer registers, any display request and the read byte.
// After reset the block sweeps its whole memory, loading the hex font and
// zeroing the rest; req.ready stays low during the sweep.
// A memory access passes S_MEM and S_MEMRD; an instruction S_FETCHX, S_EXEC
// and, when it writes Vx, S_WRX; BCD writes three digits in S_BCD; a block
// store or load of V0..Vx takes a read and a write state per register. The
// single register file read port and single memory port set these steps.
// One request is in flight at a time: req.ready is high only while idle, and
// a response held by rsp.ready low keeps the block busy until transferred.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_execute
    import c8x_pkg::*;
#(
    parameter int MEM_BYTES   = 4096,
    parameter int STACK_DEPTH = 16,
    parameter int LOAD_ADDR   = 512
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    c8x_req_if.sink    req,
    c8x_rsp_if.source  rsp
);
    localparam int AW  = $clog2(MEM_BYTES);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int IW  = $clog2(STACK_DEPTH);
    localparam logic [16:0] MEM_LIMIT = 17'(MEM_BYTES);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_FETCHX = 13'b0000000000100,
        S_EXEC   = 13'b0000000001000,
        S_WRX    = 13'b0000000010000,
        S_BCD    = 13'b0000000100000,
        S_STRD   = 13'b0000001000000,
        S_STWR   = 13'b0000010000000,
        S_LDRD   = 13'b0000100000000,
        S_LDWR   = 13'b0001000000000,
        S_MEM    = 13'b0010000000000,
        S_MEMRD  = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  act_reg, act_next;
    logic [15:0] op_reg, op_next;
    logic [15:0] keys_reg, keys_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [11:0] maddr_reg, maddr_next;
    logic [7:0]  mdata_reg, mdata_next;
    logic [11:0] pc_reg, pc_next;
    logic [15:0] index_reg, index_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0]  delay_reg, delay_next;
    logic [7:0]  sound_reg, sound_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  wr_val_reg, wr_val_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]  disp_reg, disp_next;
    logic [7:0]  dx_reg, dx_next;
    logic [7:0]  dy_reg, dy_next;
    logic [11:0] daddr_reg, daddr_next;
    logic [3:0]  drows_reg, drows_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic [1:0]  hund_reg, hund_next;
    logic [3:0]  tens_reg, tens_next;
    logic [3:0]  ones_reg, ones_next;

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  mem_rd_reg;
    logic [15:0] mem_addr16;
    logic [AW-1:0] mem_idx;
    logic        mem_inrange;
    logic        mem_we;
    logic [7:0]  mem_wdata;

    logic [7:0]  rf [16];
    logic [7:0]  rf_rd_reg;
    logic [3:0]  rf_raddr;
    logic        rf_we;
    logic [3:0]  rf_waddr;
    logic [7:0]  rf_wdata;

    logic [11:0] stk [STACK_DEPTH];
    logic        stk_we;
    logic [IW-1:0] stk_widx;
    logic [11:0] stk_wdata;
    logic [SPW-1:0] sp_dec;

    alu_res_t    alu;
    logic [11:0] pc_adv;
    logic [7:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_tens;
    logic [1:0]  bcd_hund;

    c8x_alu u_alu (
        .op    (op_reg),
        .vx    (vx_reg),
        .vy    (rf_rd_reg),
        .keys  (keys_reg),
        .rnd   (rnd_reg),
        .delay (delay_reg),
        .res   (alu)
    );

    assign mem_idx     = mem_addr16[AW-1:0];
    assign mem_inrange = ({1'b0, mem_addr16} < MEM_LIMIT);
    assign pc_adv      = pc_reg + 12'd2;
    assign sp_dec      = (sp_reg != '0) ? sp_reg - SPW'(1) : '0;

    always_comb
    begin
        bcd_hund = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
        bcd_rem  = vx_reg - ((vx_reg >= 8'd200) ? 8'd200 :
                             ((vx_reg >= 8'd100) ? 8'd100 : 8'd0));
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_tens = bcd_prod[14:11];
    end

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        op_next     = op_reg;
        keys_next   = keys_reg;
        rnd_next    = rnd_reg;
        maddr_next  = maddr_reg;
        mdata_next  = mdata_reg;
        pc_next     = pc_reg;
        index_next  = index_reg;
        sp_next     = sp_reg;
        delay_next  = delay_reg;
        sound_next  = sound_reg;
        vx_next     = vx_reg;
        wr_val_next = wr_val_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        disp_next   = disp_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        daddr_next  = daddr_reg;
        drows_next  = drows_reg;
        rdata_next  = rdata_reg;
        hund_next   = hund_reg;
        tens_next   = tens_reg;
        ones_next   = ones_reg;
        mem_addr16  = index_reg + {12'd0, cnt_reg};
        mem_we      = 1'b0;
        mem_wdata   = rf_rd_reg;
        rf_raddr    = cnt_reg;
        rf_we       = 1'b0;
        rf_waddr    = cnt_reg;
        rf_wdata    = mem_rd_reg;
        stk_we      = 1'b0;
        stk_widx    = sp_reg[IW-1:0];
        stk_wdata   = pc_adv;
        req.ready   = 1'b0;
        rsp.valid   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_addr16 = 16'(clr_reg);
                mem_we = 1'b1;
                mem_wdata = (clr_reg < AW'(FONT_BYTES)) ? font_byte(clr_reg[6:0]) : 8'h00;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MEM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                rf_raddr = req.opcode[11:8];
                if (req.valid)
                begin
                    act_next   = req.action;
                    op_next    = req.opcode;
                    keys_next  = req.keys_down;
                    rnd_next   = req.random_byte;
                    maddr_next = req.mem_addr;
                    mdata_next = req.mem_data;
                    disp_next  = DISP_NONE;
                    dx_next    = 8'd0;
                    dy_next    = 8'd0;
                    daddr_next = 12'd0;
                    drows_next = 4'd0;
                    rdata_next = 8'd0;
                    cnt_next   = 4'd0;
                    state_next = (req.action == ACT_EXEC) ? S_FETCHX : S_MEM;
                end
            end
            S_FETCHX:
            begin
                vx_next = rf_rd_reg;
                rf_raddr = (op_reg[15:12] == GRP_JPV0) ? 4'h0 : op_reg[7:4];
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                pc_next = pc_adv;
                state_next = S_OUT;
                if (op_reg == OP_CLS)
                begin
                    disp_next = DISP_CLEAR;
                end
                else if (op_reg == OP_RET)
                begin
                    pc_next = stk[sp_dec[IW-1:0]];
                    sp_next = sp_dec;
                end
                else
                begin
                    case (op_reg[15:12])
                        GRP_JP: pc_next = op_reg[11:0];
                        GRP_CALL:
                        begin
                            stk_we = 1'b1;
                            if (sp_reg < SPW'(STACK_DEPTH))
                            begin
                                sp_next = sp_reg + SPW'(1);
                            end
                            else
                            begin
                                stk_widx = IW'(STACK_DEPTH - 1);
                            end
                            pc_next = op_reg[11:0];
                        end
                        GRP_JPV0: pc_next = op_reg[11:0] + {4'd0, rf_rd_reg};
                        GRP_LDI:  index_next = {4'd0, op_reg[11:0]};
                        GRP_DRW:
                        begin
                            disp_next  = DISP_DRAW;
                            dx_next    = vx_reg;
                            dy_next    = rf_rd_reg;
                            daddr_next = index_reg[11:0];
                            drows_next = op_reg[3:0];
                        end
                        GRP_MISC:
                        begin
                            case (op_reg[7:0])
                                KK_SETDT: delay_next = vx_reg;
                                KK_SETST: sound_next = vx_reg;
                                KK_ADDI:  index_next = index_reg + {8'd0, vx_reg};
                                KK_FONT:  index_next = {6'd0, vx_reg, 2'b00} + {8'd0, vx_reg};
                                KK_BCD:
                                begin
                                    hund_next = bcd_hund;
                                    tens_next = bcd_tens;
                                    ones_next = 4'(bcd_rem - {bcd_tens, 3'b000}
                                                - {3'd0, bcd_tens, 1'b0});
                                    state_next = S_BCD;
                                end
                                KK_STORE: state_next = S_STRD;
                                KK_LOAD:  state_next = S_LDRD;
                                default:  state_next = S_OUT;
                            endcase
                        end
                        default: pc_next = pc_adv;
                    endcase
                    if (alu.skip)
                    begin
                        pc_next = pc_adv + 12'd2;
                    end
                    if (alu.hold)
                    begin
                        pc_next = pc_reg;
                    end
                    if (alu.vf_we)
                    begin
                        rf_we = 1'b1;
                        rf_waddr = VF_IDX;
                        rf_wdata = alu.vf_val;
                    end
                    if (alu.vx_we)
                    begin
                        wr_val_next = alu.vx_val;
                        state_next = S_WRX;
                    end
                end
            end
            S_WRX:
            begin
                rf_we = 1'b1;
                rf_waddr = op_reg[11:8];
                rf_wdata = wr_val_reg;
                state_next = S_OUT;
            end
            S_BCD:
            begin
                mem_we = mem_inrange;
                mem_wdata = (cnt_reg == 4'd0) ? {6'd0, hund_reg} :
                            ((cnt_reg == 4'd1) ? {4'd0, tens_reg} : {4'd0, ones_reg});
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd2)
                begin
                    state_next = S_OUT;
                end
            end
            S_STRD:
            begin
                state_next = S_STWR;
            end
            S_STWR:
            begin
                mem_we = mem_inrange;
                cnt_next = cnt_reg + 4'd1;
                state_next = (cnt_reg == op_reg[11:8]) ? S_OUT : S_STRD;
            end
            S_LDRD:
            begin
                state_next = S_LDWR;
            end
            S_LDWR:
            begin
                rf_we = 1'b1;
                rf_wdata = mem_inrange ? mem_rd_reg : 8'h00;
                cnt_next = cnt_reg + 4'd1;
                state_next = (cnt_reg == op_reg[11:8]) ? S_OUT : S_LDRD;
            end
            S_MEM:
            begin
                mem_addr16 = {4'd0, maddr_reg};
                mem_we = (act_reg == ACT_WRITE) && mem_inrange;
                mem_wdata = mdata_reg;
                state_next = S_MEMRD;
            end
            S_MEMRD:
            begin
                mem_addr16 = {4'd0, maddr_reg};
                rdata_next = ((act_reg == ACT_READ) && mem_inrange) ? mem_rd_reg : 8'h00;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign rsp.next_pc     = pc_reg;
    assign rsp.display_op  = disp_reg;
    assign rsp.draw_x      = dx_reg;
    assign rsp.draw_y      = dy_reg;
    assign rsp.draw_addr   = daddr_reg;
    assign rsp.draw_rows   = drows_reg;
    assign rsp.delay_value = delay_reg;
    assign rsp.sound_value = sound_reg;
    assign rsp.read_data   = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_idx] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_idx];
        rf_rd_reg  <= rf[rf_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                rf[i] <= 8'h00;
            end
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stk[i] <= 12'h000;
            end
        end
        else
        begin
            if (rf_we)
            begin
                rf[rf_waddr] <= rf_wdata;
            end
            if (stk_we)
            begin
                stk[stk_widx] <= stk_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pc_reg    <= 12'(LOAD_ADDR);
            index_reg <= 16'd0;
            sp_reg    <= '0;
            delay_reg <= 8'd0;
            sound_reg <= 8'd0;
            cnt_reg   <= 4'd0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            index_reg <= index_next;
            sp_reg    <= sp_next;
            delay_reg <= delay_next;
            sound_reg <= sound_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        op_reg     <= op_next;
        keys_reg   <= keys_next;
        rnd_reg    <= rnd_next;
        maddr_reg  <= maddr_next;
        mdata_reg  <= mdata_next;
        vx_reg     <= vx_next;
        wr_val_reg <= wr_val_next;
        disp_reg   <= disp_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        daddr_reg  <= daddr_next;
        drows_reg  <= drows_next;
        rdata_reg  <= rdata_next;
        hund_reg   <= hund_next;
        tens_reg   <= tens_next;
        ones_reg   <= ones_next;
    end
endmodule
`default_nettype wire

@@ rtl/c8x_alu.sv @@
// Combinational ALU: register results, VF flag, skip and key-wait decisions.
`timescale 1ns / 1ps
`default_nettype none
module c8x_alu
    import c8x_pkg::*;
(
    input  wire logic [15:0] op,
    input  wire logic [7:0]  vx,
    input  wire logic [7:0]  vy,
    input  wire logic [15:0] keys,
    input  wire logic [7:0]  rnd,
    input  wire logic [7:0]  delay,
    output alu_res_t         res
);
    logic [8:0] sum;
    logic       down;
    logic [3:0] low_key;
    logic [7:0] kk;

    always_comb
    begin
        kk = op[7:0];
        sum = {1'b0, vx} + {1'b0, vy};
        down = (vx[7:4] == 4'h0) && keys[vx[3:0]];
        low_key = 4'h0;
        for (int i = 15; i >= 0; i--)
        begin
            if (keys[i])
            begin
                low_key = 4'(i);
            end
        end
        res = '0;
        case (op[15:12])
            GRP_SE:   res.skip = (vx == kk);
            GRP_SNE:  res.skip = (vx != kk);
            GRP_SER:  res.skip = (vx == vy);
            GRP_SNER: res.skip = (vx != vy);
            GRP_LD:
            begin
                res.vx_we = 1'b1;
                res.vx_val = kk;
            end
            GRP_ADD:
            begin
                res.vx_we = 1'b1;
                res.vx_val = vx + kk;
            end
            GRP_RND:
            begin
                res.vx_we = 1'b1;
                res.vx_val = rnd & kk;
            end
            GRP_ALU:
            begin
                res.vx_we = 1'b1;
                case (op[3:0])
                    ALU_MOV: res.vx_val = vy;
                    ALU_OR:  res.vx_val = vx | vy;
                    ALU_AND: res.vx_val = vx & vy;
                    ALU_XOR: res.vx_val = vx ^ vy;
                    ALU_ADD:
                    begin
                        res.vf_we = 1'b1;
                        res.vf_val = {7'd0, sum[8]};
                        res.vx_val = sum[7:0];
                    end
                    ALU_SUB:
                    begin
                        res.vf_we = 1'b1;
                        res.vf_val = {7'd0, vx > vy};
                        res.vx_val = vx - vy;
                    end
                    ALU_SHR:
                    begin
                        res.vf_we = 1'b1;
                        res.vf_val = {7'd0, vx[0]};
                        res.vx_val = {1'b0, vx[7:1]};
                    end
                    ALU_SUBN:
                    begin
                        res.vf_we = 1'b1;
                        res.vf_val = {7'd0, vy > vx};
                        res.vx_val = vy - vx;
                    end
                    ALU_SHL:
                    begin
                        res.vf_we = 1'b1;
                        res.vf_val = {7'd0, vx[7]};
                        res.vx_val = {vx[6:0], 1'b0};
                    end
                    default: res.vx_we = 1'b0;
                endcase
            end
            GRP_KEY:
            begin
                res.skip = ((kk == KK_SKP) && down) || ((kk == KK_SKNP) && !down);
            end
            GRP_MISC:
            begin
                if (kk == KK_GETDT)
                begin
                    res.vx_we = 1'b1;
                    res.vx_val = delay;
                end
                else if (kk == KK_WAITK)
                begin
                    if (keys == 16'h0000)
                    begin
                        res.hold = 1'b1;
                    end
                    else
                    begin
                        res.vx_we = 1'b1;
                        res.vx_val = {4'h0, low_key};
                    end
                end
            end
            default: res = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/c8x_check.sv @@
// Port-level checker for the CHIP-8 executor and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module c8x_check
    import c8x_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] display_op,
    input wire logic [7:0] draw_x,
    input wire logic [3:0] draw_rows,
    input wire logic [7:0] read_data
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while a response is pending");

    a_single_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid)
        else $error("response repeated after transfer");

    a_draw_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (display_op != DISP_DRAW) |-> (draw_x == 8'd0) && (draw_rows == 4'd0))
        else $error("draw fields set without a draw request");

    a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (display_op != DISP_NONE) |-> (read_data == 8'd0))
        else $error("read data set on a display request");
endmodule

bind chip8_instruction_execute c8x_check u_c8x_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .display_op (rsp.display_op),
    .draw_x     (rsp.draw_x),
    .draw_rows  (rsp.draw_rows),
    .read_data  (rsp.read_data)
);
`default_nettype wire

@@ verif/chip8_instruction_execute_test.sv @@
// Self-checking testbench of the CHIP-8 executor: directed table, random programs, scoreboard.
`timescale 1ns / 1ps
module chip8_instruction_execute_test;
    import c8x_pkg::*;

    typedef struct {
        logic [11:0] next_pc;
        logic [1:0]  display_op;
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [11:0] draw_addr;
        logic [3:0]  draw_rows;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
        logic [7:0]  read_data;
    } cpu_resp_t;

    typedef struct {
        logic [1:0]  action;
        logic [15:0] opcode;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic [11:0] addr;
        logic [7:0]  data;
        logic        typed;
        logic [11:0] want_pc;
        logic [7:0]  want_rd;
    } stim_row_t;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int NUM_RANDOM = 1900;

    logic clk;
    logic rst_n;
    c8x_req_if req ();
    c8x_rsp_if rsp ();

    chip8_instruction_execute u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [7:0]  vreg [16];
    logic [15:0] ireg;
    logic [11:0] pc_q;
    logic [11:0] call_stack [16];
    int          sp_q;
    logic [7:0]  dt_q;
    logic [7:0]  st_q;
    logic [7:0]  ram [4096];

    cpu_resp_t pending_resp [$];
    int errors = 0;
    int n_sent = 0;
    int n_seen = 0;
    int n_draw = 0;
    int n_block = 0;
    logic long_hold = 1'b0;

    const logic [7:0] font_rom [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    stim_row_t directed_rows [] = '{
        '{ACT_READ,  16'h0000, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b1, 12'd512, 8'hF0},
        '{ACT_NONE,  16'hFFFF, 16'hFFFF, 8'hFF, 12'h000, 8'hFF, 1'b1, 12'd512, 8'h00},
        '{ACT_WRITE, 16'h0000, 16'h0000, 8'h00, 12'hFFF, 8'hFF, 1'b0, 12'd0, 8'h00},
        '{ACT_READ,  16'h0000, 16'h0000, 8'h00, 12'hFFF, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h60FF, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h6101, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h8014, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h8015, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h8107, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hC2FF, 16'h0000, 8'hA5, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h822E, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h8F24, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h00EE, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h00E0, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hD01F, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hE09E, 16'hFFFF, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hE1A1, 16'h0002, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hF30A, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hF30A, 16'h8000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hAFFE, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hF033, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hFF55, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hFF65, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hF015, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'h0123, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00},
        '{ACT_EXEC,  16'hBFFF, 16'h0000, 8'h00, 12'h000, 8'h00, 1'b0, 12'd0, 8'h00}
    };

    function automatic logic [7:0] ram_rd(input logic [15:0] a);
        return (a < 16'd4096) ? ram[a[11:0]] : 8'h00;
    endfunction

    function automatic void ram_wr(input logic [15:0] a, input logic [7:0] d);
        if (a < 16'd4096)
            ram[a[11:0]] = d;
    endfunction

    task automatic cpu_reset();
        for (int i = 0; i < 16; i++)
        begin
            vreg[i] = 8'h00;
            call_stack[i] = 12'h000;
        end
        for (int i = 0; i < 4096; i++)
            ram[i] = (i < 80) ? font_rom[i] : 8'h00;
        ireg = 16'h0000;
        pc_q = 12'd512;
        sp_q = 0;
        dt_q = 8'h00;
        st_q = 8'h00;
    endtask

    function automatic void execute_op(input logic [15:0] op, input logic [15:0] keys,
                                       input logic [7:0] rnd, inout cpu_resp_t r);
        logic [11:0] npc;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  kk;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [8:0]  sum;
        logic        down;
        int          k;
        npc = pc_q + 12'd2;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        kk = op[7:0];
        vx = vreg[x];
        vy = vreg[y];
        if (op == OP_CLS)
            r.display_op = DISP_CLEAR;
        else if (op == OP_RET)
        begin
            if (sp_q > 0)
                sp_q--;
            npc = call_stack[sp_q];
        end
        else
        begin
            case (op[15:12])
                GRP_JP: npc = op[11:0];
                GRP_CALL:
                begin
                    if (sp_q < 16)
                    begin
                        call_stack[sp_q] = npc;
                        sp_q++;
                    end
                    else
                        call_stack[15] = npc;
                    npc = op[11:0];
                end
                GRP_SE:   if (vx == kk) npc += 12'd2;
                GRP_SNE:  if (vx != kk) npc += 12'd2;
                GRP_SER:  if (vx == vy) npc += 12'd2;
                GRP_LD:   vreg[x] = kk;
                GRP_ADD:  vreg[x] = vx + kk;
                GRP_ALU:
                    case (n)
                        ALU_MOV: vreg[x] = vy;
                        ALU_OR:  vreg[x] = vx | vy;
                        ALU_AND: vreg[x] = vx & vy;
                        ALU_XOR: vreg[x] = vx ^ vy;
                        ALU_ADD:
                        begin
                            sum = {1'b0, vx} + {1'b0, vy};
                            vreg[VF_IDX] = {7'd0, sum[8]};
                            vreg[x] = sum[7:0];
                        end
                        ALU_SUB:
                        begin
                            vreg[VF_IDX] = {7'd0, vx > vy};
                            vreg[x] = vx - vy;
                        end
                        ALU_SHR:
                        begin
                            vreg[VF_IDX] = {7'd0, vx[0]};
                            vreg[x] = vx >> 1;
                        end
                        ALU_SUBN:
                        begin
                            vreg[VF_IDX] = {7'd0, vy > vx};
                            vreg[x] = vy - vx;
                        end
                        ALU_SHL:
                        begin
                            vreg[VF_IDX] = {7'd0, vx[7]};
                            vreg[x] = vx << 1;
                        end
                        default: ;
                    endcase
                GRP_SNER: if (vx != vy) npc += 12'd2;
                GRP_LDI:  ireg = {4'd0, op[11:0]};
                GRP_JPV0: npc = op[11:0] + {4'd0, vreg[0]};
                GRP_RND:  vreg[x] = rnd & kk;
                GRP_DRW:
                begin
                    r.display_op = DISP_DRAW;
                    r.draw_x = vx;
                    r.draw_y = vy;
                    r.draw_addr = ireg[11:0];
                    r.draw_rows = n;
                end
                GRP_KEY:
                begin
                    down = (vx < 8'd16) && keys[vx[3:0]];
                    if (kk == KK_SKP && down)
                        npc += 12'd2;
                    if (kk == KK_SKNP && !down)
                        npc += 12'd2;
                end
                GRP_MISC:
                    case (kk)
                        KK_GETDT: vreg[x] = dt_q;
                        KK_WAITK:
                            if (keys == 16'h0000)
                                npc = pc_q;
                            else
                            begin
                                for (k = 0; k < 16; k++)
                                    if (keys[k])
                                        break;
                                vreg[x] = k[7:0];
                            end
                        KK_SETDT: dt_q = vx;
                        KK_SETST: st_q = vx;
                        KK_ADDI:  ireg = ireg + {8'd0, vx};
                        KK_FONT:  ireg = {8'd0, vx} * 16'd5;
                        KK_BCD:
                        begin
                            ram_wr(ireg, 8'(vx / 8'd100));
                            ram_wr(ireg + 16'd1, 8'((vx / 8'd10) % 8'd10));
                            ram_wr(ireg + 16'd2, 8'(vx % 8'd10));
                        end
                        KK_STORE:
                            for (k = 0; k <= x; k++)
                                ram_wr(ireg + 16'(k), vreg[k]);
                        KK_LOAD:
                            for (k = 0; k <= x; k++)
                                vreg[k] = ram_rd(ireg + 16'(k));
                        default: ;
                    endcase
                default: ;
            endcase
        end
        pc_q = npc;
    endfunction

    function automatic cpu_resp_t cpu_step(input stim_row_t s);
        cpu_resp_t r;
        r = '{default: '0};
        if (s.action == ACT_EXEC)
            execute_op(s.opcode, s.keys, s.rnd, r);
        else if (s.action == ACT_WRITE)
            ram_wr({4'd0, s.addr}, s.data);
        else if (s.action == ACT_READ)
            r.read_data = ram_rd({4'd0, s.addr});
        r.next_pc = pc_q;
        r.delay_value = dt_q;
        r.sound_value = st_q;
        return r;
    endfunction

    function automatic logic [15:0] pick_opcode(input bit call_heavy);
        logic [15:0] op;
        logic [7:0]  misc_kk [11] = '{KK_GETDT, KK_WAITK, KK_SETDT, KK_SETST, KK_ADDI,
                                      KK_FONT, KK_BCD, KK_STORE, KK_LOAD, 8'h00, 8'hFF};
        logic [3:0]  alu_n [10] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                                    ALU_SHR, ALU_SUBN, ALU_SHL, 4'hF};
        op = 16'($urandom);
        if (call_heavy && $urandom_range(0, 2) == 0)
            op[15:12] = GRP_CALL;
        case (op[15:12])
            4'h0:
                case ($urandom_range(0, 3))
                    0: op = OP_CLS;
                    1, 2: op = OP_RET;
                    default: ;
                endcase
            GRP_ALU:
                if ($urandom_range(0, 9) != 0)
                    op[3:0] = alu_n[$urandom_range(0, 9)];
            GRP_KEY:
                if ($urandom_range(0, 7) != 0)
                    op[7:0] = $urandom_range(0, 1) ? KK_SKP : KK_SKNP;
            GRP_MISC:
            begin
                if ($urandom_range(0, 9) != 0)
                    op[7:0] = misc_kk[$urandom_range(0, 10)];
                if ((op[7:0] == KK_STORE || op[7:0] == KK_LOAD) && $urandom_range(0, 3) != 0)
                    op[11:8] = 4'($urandom_range(0, 3));
            end
            GRP_LD:
                if ($urandom_range(0, 1) == 0)
                    op[7:0] = 8'($urandom_range(0, 17));
            default: ;
        endcase
        return op;
    endfunction

    function automatic stim_row_t pick_item(input bit call_heavy);
        stim_row_t s;
        s = '{default: '0};
        s.opcode = pick_opcode(call_heavy);
        s.keys = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
        s.rnd = 8'($urandom);
        s.addr = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 95)) : 12'($urandom);
        s.data = 8'($urandom);
        case ($urandom_range(0, 19))
            0, 1: s.action = ACT_WRITE;
            2, 3: s.action = ACT_READ;
            4:    s.action = ACT_NONE;
            default: s.action = ACT_EXEC;
        endcase
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input stim_row_t s, input bit use_typed);
        cpu_resp_t want;
        int gap;
        req.valid       <= 1'b1;
        req.action      <= s.action;
        req.opcode      <= s.opcode;
        req.keys_down   <= s.keys;
        req.random_byte <= s.rnd;
        req.mem_addr    <= s.addr;
        req.mem_data    <= s.data;
        do
            @(negedge clk);
        while (!req.ready);
        @(posedge clk);
        want = cpu_step(s);
        if (use_typed && s.typed)
        begin
            want = '{default: '0};
            want.next_pc = s.want_pc;
            want.read_data = s.want_rd;
        end
        if (s.action == ACT_EXEC && s.opcode[15:12] == GRP_DRW)
            n_draw++;
        if (s.action == ACT_EXEC && s.opcode[15:12] == GRP_MISC &&
            (s.opcode[7:0] == KK_STORE || s.opcode[7:0] == KK_LOAD))
            n_block++;
        pending_resp.push_back(want);
        n_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (long_hold)
            rsp.ready <= 1'b0;
        else if ($urandom_range(0, 99) < 35)
            rsp.ready <= 1'b1;
        else if ($urandom_range(0, 99) < 8)
            rsp.ready <= 1'b0;
    end

    initial
    begin
        wait (n_sent == 400);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(negedge clk)
    begin
        cpu_resp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            n_seen++;
            if (pending_resp.size() == 0)
            begin
                $error("response transfer with no expected response");
                errors++;
            end
            else
            begin
                want = pending_resp.pop_front();
                check_field("next_pc", want.next_pc, rsp.next_pc);
                check_field("display_op", want.display_op, rsp.display_op);
                check_field("draw_x", want.draw_x, rsp.draw_x);
                check_field("draw_y", want.draw_y, rsp.draw_y);
                check_field("draw_addr", want.draw_addr, rsp.draw_addr);
                check_field("draw_rows", want.draw_rows, rsp.draw_rows);
                check_field("delay_value", want.delay_value, rsp.delay_value);
                check_field("sound_value", want.sound_value, rsp.sound_value);
                check_field("read_data", want.read_data, rsp.read_data);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("chip8_instruction_execute verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.action = ACT_EXEC;
        req.opcode = 16'h0000;
        req.keys_down = 16'h0000;
        req.random_byte = 8'h00;
        req.mem_addr = 12'h000;
        req.mem_data = 8'h00;
        rsp.ready = 1'b0;
        cpu_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i], 1'b1);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == 1000)
            begin
                req.valid <= 1'b0;
                wait (pending_resp.size() == 0);
                @(posedge clk);
            end
            send_item(pick_item(i >= 100 && i < 300), 1'b0);
        end
        req.valid <= 1'b0;

        wait (pending_resp.size() == 0);
        repeat (50) @(posedge clk);
        $display("Covered %0d transfers, %0d responses, %0d draws, %0d block moves.",
                 n_sent, n_seen, n_draw, n_block);
        $display("Included stack overflow, key wait hold, memory edges and output stalls.");
        if (errors == 0 && pending_resp.size() == 0)
            $display("chip8_instruction_execute verification clean");
        else
            $display("chip8_instruction_execute verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/c8x_pkg.sv
rtl/c8x_if.sv
rtl/c8x_alu.sv
rtl/chip8_instruction_execute.sv
rtl/c8x_check.sv
verif/chip8_instruction_execute_test.sv
